// ----- src/frustum_box_cull_top_defines.svh -----
// ------------------------------------------------------------------------
// Assertion macros for the frustum box cull block
// Short forms for concurrent checks clocked on clock, off during reset.
// ------------------------------------------------------------------------
`ifndef FRUSTUM_BOX_CULL_TOP_DEFINES_SVH
`define FRUSTUM_BOX_CULL_TOP_DEFINES_SVH

// condition must hold at every edge
`define FBC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FBC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/fbc_pkg.sv -----
// ------------------------------------------------------------------------
// fbc_pkg
// Shared types and constants of the frustum box cull pipeline.
// ------------------------------------------------------------------------
package fbc_pkg;

   localparam int NUM_PLANES   = 6;
   localparam int NUM_CORNERS  = 8;
   localparam int NUM_LANES    = 4;
   localparam int LANE_BITS    = 16;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_BITS     = 64;

   typedef enum logic {
      CMD_WORLD = 1'b0,
      CMD_MODEL = 1'b1
   } fbc_cmd_type;

   // control that travels with each request down the chain
   typedef struct packed {
      logic        valid;
      fbc_cmd_type command;
      logic        culled;
   } fbc_ctrl_type;

endpackage

// ----- src/fbc_xform.sv -----
// ------------------------------------------------------------------------
// fbc_xform
// Head stage: transforms the eight box corners by the request matrix.
// ------------------------------------------------------------------------
module fbc_xform #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 8,
   parameter int TW         = 2 * COORD_BITS + FRAC_BITS + 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  fbc_pkg::fbc_ctrl_type       ctrl_in,
   input  logic signed [COORD_BITS-1:0] lo_in   [3],
   input  logic signed [COORD_BITS-1:0] hi_in   [3],
   input  logic signed [COORD_BITS-1:0] row_in  [4][4],
   output fbc_pkg::fbc_ctrl_type       ctrl_out,
   output logic signed [COORD_BITS-1:0] lo_out  [3],
   output logic signed [COORD_BITS-1:0] hi_out  [3],
   output logic signed [TW-1:0]         tc_out  [8][4]
);

   fbc_pkg::fbc_ctrl_type        ctrl_ff;
   logic signed [COORD_BITS-1:0] lo_ff [3];
   logic signed [COORD_BITS-1:0] hi_ff [3];
   logic signed [TW-1:0]         tc_ff [8][4];
   logic signed [TW-1:0]         tc_in [8][4];

   always_comb begin
      logic signed [TW-1:0] v [3];
      logic signed [TW-1:0] acc;
      for (int j = 0; j < fbc_pkg::NUM_CORNERS; j++) begin
         v[0] = TW'(j[0] ? hi_in[0] : lo_in[0]);
         v[1] = TW'(j[1] ? hi_in[1] : lo_in[1]);
         v[2] = TW'(j[2] ? hi_in[2] : lo_in[2]);
         for (int r = 0; r < fbc_pkg::NUM_LANES; r++) begin
            // w = 1 term is a shift
            acc = TW'(row_in[r][3]) <<< FRAC_BITS;
            for (int k = 0; k < 3; k++) begin
               acc = acc + TW'(row_in[r][k]) * v[k];
            end
            tc_in[j][r] = acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
      if (advance) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         tc_ff <= tc_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign lo_out   = lo_ff;
   assign hi_out   = hi_ff;
   assign tc_out   = tc_ff;

endmodule

// ----- src/fbc_plane_cell.sv -----
// ------------------------------------------------------------------------
// fbc_plane_cell
// One plane of the frustum: holds its coefficients, tests the request.
// ------------------------------------------------------------------------
module fbc_plane_cell #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 8,
   parameter int INDEX      = 0,
   parameter int TW         = 2 * COORD_BITS + FRAC_BITS + 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  csr_wr_en,
   input  logic [fbc_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [fbc_pkg::CSR_BITS-1:0]          csr_wdata,
   input  fbc_pkg::fbc_ctrl_type                 ctrl_in,
   input  logic signed [COORD_BITS-1:0]          lo_in  [3],
   input  logic signed [COORD_BITS-1:0]          hi_in  [3],
   input  logic signed [TW-1:0]                  tc_in  [8][4],
   output fbc_pkg::fbc_ctrl_type                 ctrl_out,
   output logic signed [COORD_BITS-1:0]          lo_out [3],
   output logic signed [COORD_BITS-1:0]          hi_out [3],
   output logic signed [TW-1:0]                  tc_out [8][4]
);

   localparam int WW = 2 * COORD_BITS + FRAC_BITS + 2;
   localparam int DW = COORD_BITS + TW + 2;
   localparam logic [fbc_pkg::CSR_IDX_BITS-1:0] MyIndex = fbc_pkg::CSR_IDX_BITS'(INDEX);

   logic [fbc_pkg::CSR_BITS-1:0] plane_ff;
   fbc_pkg::fbc_ctrl_type        ctrl_ff;
   fbc_pkg::fbc_ctrl_type        ctrl_in_next;
   logic signed [COORD_BITS-1:0] lo_ff [3];
   logic signed [COORD_BITS-1:0] hi_ff [3];
   logic signed [TW-1:0]         tc_ff [8][4];
   logic                         plane_cull;

   always_comb begin
      logic signed [COORD_BITS-1:0] c [4];
      logic signed [WW-1:0]         w_acc;
      logic signed [DW-1:0]         d_acc;
      logic                         any_pos;
      for (int k = 0; k < fbc_pkg::NUM_LANES; k++) begin
         c[k] = plane_ff[k*fbc_pkg::LANE_BITS +: COORD_BITS];
      end
      // world: nearest-positive corner along the normal
      w_acc = WW'(c[3]) <<< FRAC_BITS;
      for (int i = 0; i < 3; i++) begin
         w_acc = w_acc + WW'(c[i]) * WW'(c[i][COORD_BITS-1] ? lo_in[i] : hi_in[i]);
      end
      // model: some transformed corner strictly inside
      any_pos = 1'b0;
      for (int j = 0; j < fbc_pkg::NUM_CORNERS; j++) begin
         d_acc = '0;
         for (int k = 0; k < fbc_pkg::NUM_LANES; k++) begin
            d_acc = d_acc + DW'(c[k]) * DW'(tc_in[j][k]);
         end
         any_pos = any_pos | (d_acc > 0);
      end
      case (ctrl_in.command)
         fbc_pkg::CMD_WORLD: plane_cull = w_acc < 0;
         fbc_pkg::CMD_MODEL: plane_cull = !any_pos;
         default:            plane_cull = 1'b0;
      endcase
   end

   always_comb begin
      ctrl_in_next        = ctrl_in;
      ctrl_in_next.culled = ctrl_in.culled | plane_cull;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
         ctrl_ff  <= '0;
      end else begin
         if (csr_wr_en && csr_index == MyIndex) begin
            plane_ff <= csr_wdata;
         end
         if (advance) begin
            ctrl_ff <= ctrl_in_next;
         end
      end
      if (advance) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         tc_ff <= tc_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign lo_out   = lo_ff;
   assign hi_out   = hi_ff;
   assign tc_out   = tc_ff;

endmodule

// ----- src/frustum_box_cull_top.sv -----
// ------------------------------------------------------------------------
// frustum_box_cull_top
// Axis-aligned box against six frustum planes, world or model space.
// ------------------------------------------------------------------------
// One request enters per cycle and one result leaves per cycle while no
// result is held under rsp_stall, and each result shows on rsp_valid.
// It passes seven register stages: one transform stage that maps the eight
// box corners through the request matrix, then a chain of six plane cells,
// one per plane, each holding its own plane register and ORing its verdict
// into the running culled flag. The transform stage captures at the
// accepting edge. The last cell's register is the output register. The
// whole chain halts while a result waits under rsp_stall; req_stall is
// high exactly then. Plane registers are written through the csr port
// (index 0..5, other indices ignored) and should only change while no
// request is in flight.
module frustum_box_cull_top #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_command,
   input  logic signed [15:0]                 req_min_x,
   input  logic signed [15:0]                 req_min_y,
   input  logic signed [15:0]                 req_min_z,
   input  logic signed [15:0]                 req_max_x,
   input  logic signed [15:0]                 req_max_y,
   input  logic signed [15:0]                 req_max_z,
   input  logic [63:0]                        req_xform_row0,
   input  logic [63:0]                        req_xform_row1,
   input  logic [63:0]                        req_xform_row2,
   input  logic [63:0]                        req_xform_row3,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_culled,
   input  logic                               csr_wr_en,
   input  logic [fbc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [fbc_pkg::CSR_BITS-1:0]       csr_wdata
);

`include "frustum_box_cull_top_defines.svh"

   localparam int TW = 2 * COORD_BITS + FRAC_BITS + 2;
   localparam int NP = fbc_pkg::NUM_PLANES;

   logic                         advance;
   fbc_pkg::fbc_ctrl_type        req_ctrl;
   logic signed [COORD_BITS-1:0] req_lo  [3];
   logic signed [COORD_BITS-1:0] req_hi  [3];
   logic signed [COORD_BITS-1:0] req_row [4][4];
   logic [63:0]                  rows    [4];

   // chain links: index 0 is the transform output, NP the last cell
   fbc_pkg::fbc_ctrl_type        ctrl_c [NP+1];
   logic signed [COORD_BITS-1:0] lo_c   [NP+1][3];
   logic signed [COORD_BITS-1:0] hi_c   [NP+1][3];
   logic signed [TW-1:0]         tc_c   [NP+1][8][4];

   // chain moves unless a finished result is held
   assign advance   = !(ctrl_c[NP].valid && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      req_ctrl.valid   = req_valid;
      req_ctrl.command = fbc_pkg::fbc_cmd_type'(req_command);
      req_ctrl.culled  = 1'b0;
   end

   // only the low COORD_BITS of each field or lane count
   assign req_lo[0] = req_min_x[COORD_BITS-1:0];
   assign req_lo[1] = req_min_y[COORD_BITS-1:0];
   assign req_lo[2] = req_min_z[COORD_BITS-1:0];
   assign req_hi[0] = req_max_x[COORD_BITS-1:0];
   assign req_hi[1] = req_max_y[COORD_BITS-1:0];
   assign req_hi[2] = req_max_z[COORD_BITS-1:0];

   assign rows[0] = req_xform_row0;
   assign rows[1] = req_xform_row1;
   assign rows[2] = req_xform_row2;
   assign rows[3] = req_xform_row3;

   always_comb begin
      for (int r = 0; r < fbc_pkg::NUM_LANES; r++) begin
         for (int k = 0; k < fbc_pkg::NUM_LANES; k++) begin
            req_row[r][k] = rows[r][k*fbc_pkg::LANE_BITS +: COORD_BITS];
         end
      end
   end

   fbc_xform #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .TW         (TW)
   ) u_xform (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .ctrl_in  (req_ctrl),
      .lo_in    (req_lo),
      .hi_in    (req_hi),
      .row_in   (req_row),
      .ctrl_out (ctrl_c[0]),
      .lo_out   (lo_c[0]),
      .hi_out   (hi_c[0]),
      .tc_out   (tc_c[0])
   );

   for (genvar p = 0; p < NP; p++) begin : g_cell
      fbc_plane_cell #(
         .COORD_BITS (COORD_BITS),
         .FRAC_BITS  (FRAC_BITS),
         .INDEX      (p),
         .TW         (TW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .csr_wr_en (csr_wr_en),
         .csr_index (csr_index),
         .csr_wdata (csr_wdata),
         .ctrl_in   (ctrl_c[p]),
         .lo_in     (lo_c[p]),
         .hi_in     (hi_c[p]),
         .tc_in     (tc_c[p]),
         .ctrl_out  (ctrl_c[p+1]),
         .lo_out    (lo_c[p+1]),
         .hi_out    (hi_c[p+1]),
         .tc_out    (tc_c[p+1])
      );
   end

   assign rsp_valid  = ctrl_c[NP].valid;
   assign rsp_culled = ctrl_c[NP].culled;

   // an accepted request shows up in the transform stage
   `FBC_ASSERT_NEXT(a_req_enters, req_valid && !req_stall, ctrl_c[0].valid, "request lost at entry")
   // a culled verdict is never cleared further down the chain
   `FBC_ASSERT_NEXT(a_cull_sticks, advance && ctrl_c[0].valid && ctrl_c[0].culled, ctrl_c[1].culled, "cull flag dropped")
   // a held result freezes the first cell too
   `FBC_ASSERT_NEXT(a_chain_holds, !advance, $stable(ctrl_c[1]), "chain moved during stall")

endmodule
